// ----- rtl/core/dsg_pkg.sv -----
package dsg_pkg;

  localparam int IdxW    = 10;
  localparam int DataW   = 32;
  localparam int DiffW   = 33;
  localparam int SqW     = 66;
  localparam int RootW   = 33;
  localparam int QW      = 17;
  localparam int CfgIdxW = 2;
  localparam int MaxParticles = 1024;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgStiffness  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRestLength = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDamping    = 2'd2;

  localparam logic [DataW-1:0] StiffnessRst  = 32'h0001_0000;
  localparam logic [DataW-1:0] RestLengthRst = 32'h0001_0000;
  localparam logic [DataW-1:0] DampingRst    = 32'h0000_0000;

  localparam logic [46:0] Lim47 = {47{1'b1}};

  typedef struct packed {
    logic [IdxW-1:0]         index_a;
    logic [IdxW-1:0]         index_b;
    logic signed [DataW-1:0] pos_ax;
    logic signed [DataW-1:0] pos_ay;
    logic signed [DataW-1:0] pos_bx;
    logic signed [DataW-1:0] pos_by;
    logic signed [DataW-1:0] vel_ax;
    logic signed [DataW-1:0] vel_ay;
    logic signed [DataW-1:0] vel_bx;
    logic signed [DataW-1:0] vel_by;
  } in_word_t;

  typedef struct packed {
    logic [IdxW-1:0]         out_index_a;
    logic [IdxW-1:0]         out_index_b;
    logic signed [DataW-1:0] grad_ax;
    logic signed [DataW-1:0] grad_ay;
    logic signed [DataW-1:0] grad_bx;
    logic signed [DataW-1:0] grad_by;
    logic                    degenerate;
  } out_word_t;

  // Per-spring data that rides along the square root and divider pipelines.
  typedef struct packed {
    logic [IdxW-1:0]         ia;
    logic [IdxW-1:0]         ib;
    logic                    idx_ok;
    logic signed [DiffW-1:0] dx;
    logic signed [DiffW-1:0] dy;
    logic signed [DiffW-1:0] dvx;
    logic signed [DiffW-1:0] dvy;
  } side_t;

  // Indices and result flags carried through the force stages.
  typedef struct packed {
    logic [IdxW-1:0] ia;
    logic [IdxW-1:0] ib;
    logic            ok;
    logic            degen;
  } tag_t;

  // Unit direction as magnitude and sign per axis.
  typedef struct packed {
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
    logic          x_neg;
    logic          y_neg;
  } dir_t;

  function automatic logic [DiffW-1:0] abs33(logic signed [DiffW-1:0] v);
    abs33 = v[DiffW-1] ? -v : v;
  endfunction

  // One restoring division step: returns the quotient bit above the new remainder.
  function automatic logic [RootW:0] div_step(logic [RootW-1:0] rem, logic inb,
                                              logic [RootW-1:0] len);
    logic [RootW:0] t;
    t = {rem, inb};
    if (t >= {1'b0, len}) begin
      div_step = {1'b1, RootW'(t - {1'b0, len})};
    end else begin
      div_step = {1'b0, t[RootW-1:0]};
    end
  endfunction

  function automatic logic [46:0] sat47(logic [51:0] v);
    sat47 = (v > 52'(Lim47)) ? Lim47 : v[46:0];
  endfunction

  function automatic logic signed [DataW-1:0] grad_pos(logic [47:0] m);
    grad_pos = (m > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
  endfunction

  function automatic logic signed [DataW-1:0] grad_neg(logic [47:0] m);
    grad_neg = (m >= 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(m[31:0]);
  endfunction

endpackage

// ----- rtl/core/dsg_if.sv -----
interface dsg_in_if;
  logic              valid;
  logic              ready;
  dsg_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dsg_out_if;
  logic               valid;
  logic               ready;
  dsg_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/dsg_sqrt.sv -----
module dsg_sqrt (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsg_pkg::SqW-1:0]     rad_i,
  input  dsg_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [dsg_pkg::RootW-1:0]   root_o,
  output dsg_pkg::side_t              side_o
);
  import dsg_pkg::*;

  localparam int Steps = RootW;
  localparam int RemW  = RootW + 2;

  logic             v_q    [Steps];
  logic [RemW-1:0]  rem_q  [Steps];
  logic [RootW-1:0] root_q [Steps];
  logic [SqW-1:0]   rad_q  [Steps];
  side_t            side_q [Steps];

  // One root bit per stage, two radicand bits brought down each time.
  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic             v_in;
    logic [RemW-1:0]  rem_in;
    logic [RootW-1:0] root_in;
    logic [SqW-1:0]   rad_in;
    side_t            side_in;
    logic [RemW+1:0]  tmp;
    logic [RemW+1:0]  trial;
    logic [RemW-1:0]  rem_d;
    logic [RootW-1:0] root_d;

    if (g == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
      assign side_in = side_q[g-1];
    end

    always_comb begin
      tmp   = {rem_in, rad_in[SqW-1 -: 2]};
      trial = {2'b00, root_in, 2'b01};
      if (tmp >= trial) begin
        rem_d  = RemW'(tmp - trial);
        root_d = {root_in[RootW-2:0], 1'b1};
      end else begin
        rem_d  = tmp[RemW-1:0];
        root_d = {root_in[RootW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_d;
        root_q[g] <= root_d;
        rad_q[g]  <= {rad_in[SqW-3:0], 2'b00};
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign root_o  = root_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ----- rtl/core/dsg_div.sv -----
module dsg_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [dsg_pkg::RootW-1:0]   len_i,
  input  dsg_pkg::side_t              side_i,
  output logic                        valid_o,
  output logic [dsg_pkg::QW-1:0]      qx_o,
  output logic [dsg_pkg::QW-1:0]      qy_o,
  output logic [dsg_pkg::RootW-1:0]   len_o,
  output dsg_pkg::side_t              side_o
);
  import dsg_pkg::*;

  localparam int Steps = QW;

  logic             v_q    [Steps];
  logic [RootW-1:0] rx_q   [Steps];
  logic [RootW-1:0] ry_q   [Steps];
  logic [QW-1:0]    qx_q   [Steps];
  logic [QW-1:0]    qy_q   [Steps];
  logic [RootW-1:0] len_q  [Steps];
  side_t            side_q [Steps];

  // Two lanes divide |dx| * 2^16 and |dy| * 2^16 by the length, one quotient
  // bit per stage. The quotient never exceeds 2^16 since each axis is at most
  // the length.
  for (genvar g = 0; g < Steps; g++) begin : g_step
    logic             v_in;
    logic [RootW-1:0] rx_in;
    logic [RootW-1:0] ry_in;
    logic [QW-1:0]    qx_in;
    logic [QW-1:0]    qy_in;
    logic [RootW-1:0] len_in;
    side_t            side_in;
    logic             bx;
    logic             by;
    logic [RootW:0]   sx;
    logic [RootW:0]   sy;

    if (g == 0) begin : g_first
      logic [DiffW-1:0] ax;
      logic [DiffW-1:0] ay;
      assign ax      = abs33(side_i.dx);
      assign ay      = abs33(side_i.dy);
      assign v_in    = valid_i;
      assign rx_in   = ax >> 1;
      assign ry_in   = ay >> 1;
      assign bx      = ax[0];
      assign by      = ay[0];
      assign qx_in   = '0;
      assign qy_in   = '0;
      assign len_in  = len_i;
      assign side_in = side_i;
    end else begin : g_next
      assign v_in    = v_q[g-1];
      assign rx_in   = rx_q[g-1];
      assign ry_in   = ry_q[g-1];
      assign bx      = 1'b0;
      assign by      = 1'b0;
      assign qx_in   = qx_q[g-1];
      assign qy_in   = qy_q[g-1];
      assign len_in  = len_q[g-1];
      assign side_in = side_q[g-1];
    end

    assign sx = div_step(rx_in, bx, len_in);
    assign sy = div_step(ry_in, by, len_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[g]   <= sx[RootW-1:0];
        ry_q[g]   <= sy[RootW-1:0];
        qx_q[g]   <= {qx_in[QW-2:0], sx[RootW]};
        qy_q[g]   <= {qy_in[QW-2:0], sy[RootW]};
        len_q[g]  <= len_in;
        side_q[g] <= side_in;
      end
    end
  end

  assign valid_o = v_q[Steps-1];
  assign qx_o    = qx_q[Steps-1];
  assign qy_o    = qy_q[Steps-1];
  assign len_o   = len_q[Steps-1];
  assign side_o  = side_q[Steps-1];

endmodule

// ----- rtl/core/damped_spring_gradient_2d_unit.sv -----
// Damped 2D spring gradient unit.
// Input channel in_i carries one spring per word: both endpoint indices and
// the positions and velocities of both endpoints, all Q16.16. Output channel
// out_o returns one word per input word, in order: the echoed indices, the
// saturated gradient contribution for each endpoint and a degenerate flag
// for coincident endpoints. Stiffness, rest length and damping are written
// through the cfg_we_i / cfg_idx_i / cfg_data_i port while the unit is idle;
// the user must ensure this, as the unit does not enforce it. Throughput is
// one word per cycle while no stall holds the pipeline. A word passes 3 front
// stages (differences, squares, sum), 33 square root stages (one root bit
// each), 17 divider stages (one quotient bit each), 7 force stages and the
// output register. Reset clears every valid bit and restores the register
// reset values. When the receiver stalls, the output register holds its word
// and one more word lands in a skid register; only then does the whole
// pipeline freeze and in_i.ready drop, so no word is lost or repeated.
module damped_spring_gradient_2d_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dsg_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [dsg_pkg::DataW-1:0]     cfg_data_i,
  dsg_in_if.sink                        in_i,
  dsg_out_if.source                     out_o
);
  import dsg_pkg::*;

  // Configuration registers.
  logic [DataW-1:0] stiffness_q, rest_length_q, damping_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stiffness_q   <= StiffnessRst;
      rest_length_q <= RestLengthRst;
      damping_q     <= DampingRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgStiffness:  stiffness_q   <= cfg_data_i;
        CfgRestLength: rest_length_q <= cfg_data_i;
        CfgDamping:    damping_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // The whole pipeline advances together; it only stops once the skid
  // register is occupied.
  logic en;
  logic skid_v_q, out_v_q;
  out_word_t skid_q, out_q;

  assign en         = !skid_v_q;
  assign in_i.ready = en;

  // Front stages: differences, squares, squared length.
  side_t            f1_side_d;
  logic             f1_v_q, f2_v_q, f3_v_q;
  side_t            f1_side_q, f2_side_q, f3_side_q;
  logic [SqW-1:0]   f2_sqx_q, f2_sqy_q, f3_n2_q;
  logic [DiffW-1:0] f1_ax, f1_ay;

  always_comb begin
    f1_side_d.ia     = in_i.data.index_a;
    f1_side_d.ib     = in_i.data.index_b;
    f1_side_d.idx_ok = (int'(in_i.data.index_a) < MaxParticles) &&
                       (int'(in_i.data.index_b) < MaxParticles);
    f1_side_d.dx     = 33'(in_i.data.pos_bx) - 33'(in_i.data.pos_ax);
    f1_side_d.dy     = 33'(in_i.data.pos_by) - 33'(in_i.data.pos_ay);
    f1_side_d.dvx    = 33'(in_i.data.vel_bx) - 33'(in_i.data.vel_ax);
    f1_side_d.dvy    = 33'(in_i.data.vel_by) - 33'(in_i.data.vel_ay);
  end

  assign f1_ax = abs33(f1_side_q.dx);
  assign f1_ay = abs33(f1_side_q.dy);

  // Square root and direction pipelines.
  logic             sq_v;
  logic [RootW-1:0] sq_root;
  side_t            sq_side;
  logic             dv_v;
  logic [QW-1:0]    dv_qx, dv_qy;
  logic [RootW-1:0] dv_len;
  side_t            dv_side;

  dsg_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (f3_v_q),
    .rad_i   (f3_n2_q),
    .side_i  (f3_side_q),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  dsg_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (sq_v),
    .len_i   (sq_root),
    .side_i  (sq_side),
    .valid_o (dv_v),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy),
    .len_o   (dv_len),
    .side_o  (dv_side)
  );

  // Force stages.
  logic                 p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q;
  tag_t                 p1_tag_q, p2_tag_q, p3_tag_q, p4_tag_q, p5_tag_q, p6_tag_q;
  tag_t                 p7_tag_q;
  dir_t                 p1_dir_q, p2_dir_q, p3_dir_q, p4_dir_q, p5_dir_q, p6_dir_q;
  tag_t                 p1_tag_d;
  dir_t                 p1_dir_d;
  logic signed [17:0]   nx, ny;
  logic signed [50:0]   p1_px_q, p1_py_q;
  logic signed [34:0]   p1_stretch_q;
  logic [33:0]          stretch_mag;
  logic signed [51:0]   p2_ps_q;
  logic [65:0]          p2_elp_q;
  logic                 p2_el_neg_q, p3_el_neg_q, p4_el_neg_q;
  logic [51:0]          ps_mag;
  logic [35:0]          p3_projm_q;
  logic                 p3_proj_neg_q, p4_proj_neg_q;
  logic [46:0]          p3_elm_q, p4_elm_q;
  logic [67:0]          p4_dmp_q;
  logic [46:0]          dm_mag;
  logic signed [47:0]   p5_el_q, p5_dm_q;
  logic signed [48:0]   s_sum;
  logic [48:0]          s_mag;
  logic [46:0]          p6_sm_q;
  logic                 p6_s_neg_q;
  logic [63:0]          p7_mxp_q, p7_myp_q;
  logic                 p7_negx_q, p7_negy_q;

  always_comb begin
    p1_dir_d.qx    = dv_qx;
    p1_dir_d.qy    = dv_qy;
    p1_dir_d.x_neg = dv_side.dx[DiffW-1];
    p1_dir_d.y_neg = dv_side.dy[DiffW-1];
    nx = dv_side.dx[DiffW-1] ? -$signed({1'b0, dv_qx}) : $signed({1'b0, dv_qx});
    ny = dv_side.dy[DiffW-1] ? -$signed({1'b0, dv_qy}) : $signed({1'b0, dv_qy});
    p1_tag_d.ia    = dv_side.ia;
    p1_tag_d.ib    = dv_side.ib;
    p1_tag_d.ok    = dv_side.idx_ok && (dv_len != '0);
    p1_tag_d.degen = dv_side.idx_ok && (dv_len == '0);
  end

  assign stretch_mag = p1_stretch_q[34] ? 34'(-p1_stretch_q) : 34'(p1_stretch_q);
  assign ps_mag      = p2_ps_q[51] ? -p2_ps_q : p2_ps_q;
  assign dm_mag      = sat47(p4_dmp_q[67:16]);
  assign s_sum       = 49'(p5_el_q) + 49'(p5_dm_q);
  assign s_mag       = s_sum[48] ? -s_sum : s_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
      f2_v_q <= 1'b0;
      f3_v_q <= 1'b0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
      p6_v_q <= 1'b0;
      p7_v_q <= 1'b0;
    end else if (en) begin
      f1_v_q <= in_i.valid;
      f2_v_q <= f1_v_q;
      f3_v_q <= f2_v_q;
      p1_v_q <= dv_v;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
      p6_v_q <= p5_v_q;
      p7_v_q <= p6_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f1_side_q <= f1_side_d;

      f2_side_q <= f1_side_q;
      f2_sqx_q  <= 66'(f1_ax) * 66'(f1_ax);
      f2_sqy_q  <= 66'(f1_ay) * 66'(f1_ay);

      f3_side_q <= f2_side_q;
      f3_n2_q   <= f2_sqx_q + f2_sqy_q;

      // Projection products and the stretch against the rest length.
      p1_tag_q     <= p1_tag_d;
      p1_dir_q     <= p1_dir_d;
      p1_px_q      <= nx * dv_side.dvx;
      p1_py_q      <= ny * dv_side.dvy;
      p1_stretch_q <= $signed({2'b00, dv_len}) - $signed({3'b000, rest_length_q});

      // Projection sum and the elastic product.
      p2_tag_q    <= p1_tag_q;
      p2_dir_q    <= p1_dir_q;
      p2_ps_q     <= 52'(p1_px_q) + 52'(p1_py_q);
      p2_elp_q    <= 66'(stiffness_q) * 66'(stretch_mag);
      p2_el_neg_q <= p1_stretch_q[34];

      // Projection truncated toward zero, elastic term saturated.
      p3_tag_q      <= p2_tag_q;
      p3_dir_q      <= p2_dir_q;
      p3_projm_q    <= ps_mag[51:16];
      p3_proj_neg_q <= p2_ps_q[51];
      p3_elm_q      <= sat47({2'b00, p2_elp_q[65:16]});
      p3_el_neg_q   <= p2_el_neg_q;

      // Damping product.
      p4_tag_q      <= p3_tag_q;
      p4_dir_q      <= p3_dir_q;
      p4_dmp_q      <= 68'(damping_q) * 68'(p3_projm_q);
      p4_proj_neg_q <= p3_proj_neg_q;
      p4_elm_q      <= p3_elm_q;
      p4_el_neg_q   <= p3_el_neg_q;

      // Both terms back in signed form.
      p5_tag_q <= p4_tag_q;
      p5_dir_q <= p4_dir_q;
      p5_el_q  <= p4_el_neg_q ? -$signed({1'b0, p4_elm_q}) : $signed({1'b0, p4_elm_q});
      p5_dm_q  <= p4_proj_neg_q ? -$signed({1'b0, dm_mag}) : $signed({1'b0, dm_mag});

      // Scalar force, clamped to 47 bits of magnitude.
      p6_tag_q   <= p5_tag_q;
      p6_dir_q   <= p5_dir_q;
      p6_sm_q    <= (s_mag > 49'(Lim47)) ? Lim47 : s_mag[46:0];
      p6_s_neg_q <= s_sum[48];

      // Force along the unit direction.
      p7_tag_q  <= p6_tag_q;
      p7_mxp_q  <= 64'(p6_sm_q) * 64'(p6_dir_q.qx);
      p7_myp_q  <= 64'(p6_sm_q) * 64'(p6_dir_q.qy);
      p7_negx_q <= p6_s_neg_q ^ p6_dir_q.x_neg;
      p7_negy_q <= p6_s_neg_q ^ p6_dir_q.y_neg;
    end
  end

  // Final word: endpoint two gets +S, endpoint one -S, each saturated on its own.
  out_word_t   fin;
  logic [47:0] mx, my;

  always_comb begin
    mx = p7_tag_q.ok ? p7_mxp_q[63:16] : '0;
    my = p7_tag_q.ok ? p7_myp_q[63:16] : '0;
    fin.out_index_a = p7_tag_q.ia;
    fin.out_index_b = p7_tag_q.ib;
    fin.grad_bx     = p7_negx_q ? grad_neg(mx) : grad_pos(mx);
    fin.grad_ax     = p7_negx_q ? grad_pos(mx) : grad_neg(mx);
    fin.grad_by     = p7_negy_q ? grad_neg(my) : grad_pos(my);
    fin.grad_ay     = p7_negy_q ? grad_pos(my) : grad_neg(my);
    fin.degenerate  = p7_tag_q.degen;
  end

  // Output register with a one-word skid behind it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_v_q && out_o.ready) begin
      if (skid_v_q) begin
        out_q    <= skid_q;
        skid_v_q <= 1'b0;
      end else if (p7_v_q) begin
        out_q <= fin;
      end else begin
        out_v_q <= 1'b0;
      end
    end else if (!out_v_q) begin
      if (en && p7_v_q) begin
        out_q   <= fin;
        out_v_q <= 1'b1;
      end
    end else if (en && p7_v_q) begin
      skid_q   <= fin;
      skid_v_q <= 1'b1;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

  // The skid register is only ever used behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid word without an output word");

  // A word waiting at the output is never dropped.
  a_out_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && !out_o.ready) |=> out_v_q)
    else $error("stalled output word lost");

  // The skid register fills only while the receiver stalls.
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_o.ready))
    else $error("skid filled without a stall");

  // Coincident endpoints give zero gradients.
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_v_q && out_q.degenerate) |->
      (out_q.grad_ax == '0 && out_q.grad_ay == '0 &&
       out_q.grad_bx == '0 && out_q.grad_by == '0))
    else $error("degenerate word with nonzero gradient");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
  import dsg_pkg::*;

  localparam int PipeLatency = 60;
  localparam int CycleLimit  = 400000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [DataW-1:0] cfg_data_i;

  dsg_in_if  in_if ();
  dsg_out_if out_if ();

  damped_spring_gradient_2d_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Our own copy of the spring registers, kept in step with every write.
  longint k_shadow;
  longint rest_shadow;
  longint damp_shadow;

  // Gradients still in flight through the pipeline, oldest first.
  out_word_t pending_grads[$];

  int     error_count;
  int     send_idle_pct;
  int     recv_stall_pct;
  longint cycle_count;

  initial begin
    clk_i = 1'b0;
  end

  always #2 clk_i = ~clk_i;

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CfgStiffness;
    cfg_data_i     = '0;
    in_if.valid    = 1'b0;
    in_if.data     = '0;
    out_if.ready   = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    error_count    = 0;
    cycle_count    = 0;
    k_shadow       = longint'(StiffnessRst);
    rest_shadow    = longint'(RestLengthRst);
    damp_shadow    = longint'(DampingRst);
  end

  // A stuck handshake must not hang the run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The receiver drops ready at random with the stall rate of the current phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic longint mag64(longint v);
    mag64 = (v < 0) ? -v : v;
  endfunction

  // Signed Q16.16 product with the magnitude cut to 47 bits.
  function automatic longint fixed_mul_clamped(longint a, longint b);
    logic [127:0] prod;
    longint       m;
    prod = (128'(mag64(a)) * 128'(mag64(b))) >> 16;
    m = (prod > 128'(Lim47)) ? longint'(Lim47) : longint'(prod[63:0]);
    fixed_mul_clamped = ((a < 0) != (b < 0)) ? -m : m;
  endfunction

  function automatic logic signed [DataW-1:0] sat_q16(longint v);
    if (v > 64'sd2147483647) begin
      sat_q16 = 32'sh7FFF_FFFF;
    end else if (v < -64'sd2147483648) begin
      sat_q16 = 32'sh8000_0000;
    end else begin
      sat_q16 = v[31:0];
    end
  endfunction

  // Unit direction component: truncated |d| * 65536 / len with the sign of d.
  function automatic longint unit_component(longint d, logic [33:0] len);
    longint q;
    q = (mag64(d) << 16) / longint'(len);
    unit_component = (d < 0) ? -q : q;
  endfunction

  function automatic out_word_t spring_gradient(in_word_t w);
    longint       dx, dy, dvx, dvy, nx, ny, ps, proj, stretch, el, dm, s;
    longint       sxv, syv;
    logic [65:0]  len_sq, cand_sq;
    logic [33:0]  len, cand;
    logic [127:0] mx, my;
    out_word_t    r;
    dx  = longint'(w.pos_bx) - longint'(w.pos_ax);
    dy  = longint'(w.pos_by) - longint'(w.pos_ay);
    dvx = longint'(w.vel_bx) - longint'(w.vel_ax);
    dvy = longint'(w.vel_by) - longint'(w.vel_ay);
    sxv = 0;
    syv = 0;
    r = '0;
    r.out_index_a = w.index_a;
    r.out_index_b = w.index_b;
    // Indices are 10 bits wide, so they are always inside the particle range.
    len_sq = 66'(mag64(dx)) * 66'(mag64(dx)) + 66'(mag64(dy)) * 66'(mag64(dy));
    len = '0;
    for (int i = 32; i >= 0; i--) begin
      cand = len | (34'd1 << i);
      cand_sq = 66'(cand) * 66'(cand);
      if (cand_sq <= len_sq) begin
        len = cand;
      end
    end
    if (len == 0) begin
      r.degenerate = 1'b1;
    end else begin
      nx = unit_component(dx, len);
      ny = unit_component(dy, len);
      ps = nx * dvx + ny * dvy;
      proj = (ps < 0) ? -(mag64(ps) >>> 16) : (ps >>> 16);
      stretch = longint'(len) - rest_shadow;
      el = fixed_mul_clamped(k_shadow, stretch);
      dm = fixed_mul_clamped(damp_shadow, proj);
      s = el + dm;
      if (s > longint'(Lim47)) begin
        s = longint'(Lim47);
      end else if (s < -longint'(Lim47)) begin
        s = -longint'(Lim47);
      end
      mx = (128'(mag64(s)) * 128'(mag64(nx))) >> 16;
      my = (128'(mag64(s)) * 128'(mag64(ny))) >> 16;
      sxv = ((s < 0) != (nx < 0)) ? -longint'(mx[63:0]) : longint'(mx[63:0]);
      syv = ((s < 0) != (ny < 0)) ? -longint'(my[63:0]) : longint'(my[63:0]);
    end
    r.grad_ax = sat_q16(-sxv);
    r.grad_ay = sat_q16(-syv);
    r.grad_bx = sat_q16(sxv);
    r.grad_by = sat_q16(syv);
    return r;
  endfunction

  // Every accepted result word is checked against the oldest expected one.
  always @(posedge clk_i) begin
    out_word_t want;
    out_word_t got;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = out_if.data;
      if (pending_grads.size() == 0) begin
        $display("%0t unexpected word: got %p", $time, got);
        error_count++;
      end else begin
        want = pending_grads.pop_front();
        if (got.out_index_a !== want.out_index_a) begin
          $display("%0t out_index_a: expected %0d actual %0d", $time,
                   want.out_index_a, got.out_index_a);
          error_count++;
        end
        if (got.out_index_b !== want.out_index_b) begin
          $display("%0t out_index_b: expected %0d actual %0d", $time,
                   want.out_index_b, got.out_index_b);
          error_count++;
        end
        if (got.grad_ax !== want.grad_ax) begin
          $display("%0t grad_ax: expected %h actual %h", $time, want.grad_ax, got.grad_ax);
          error_count++;
        end
        if (got.grad_ay !== want.grad_ay) begin
          $display("%0t grad_ay: expected %h actual %h", $time, want.grad_ay, got.grad_ay);
          error_count++;
        end
        if (got.grad_bx !== want.grad_bx) begin
          $display("%0t grad_bx: expected %h actual %h", $time, want.grad_bx, got.grad_bx);
          error_count++;
        end
        if (got.grad_by !== want.grad_by) begin
          $display("%0t grad_by: expected %h actual %h", $time, want.grad_by, got.grad_by);
          error_count++;
        end
        if (got.degenerate !== want.degenerate) begin
          $display("%0t degenerate: expected %b actual %b", $time,
                   want.degenerate, got.degenerate);
          error_count++;
        end
      end
    end
  end

  // Presents one spring word, with random idle cycles ahead of it, and
  // records its expected gradients at the edge that accepts it.
  task automatic send_spring(in_word_t w);
    out_word_t want;
    want = spring_gradient(w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    @(posedge clk_i);
    while (!in_if.ready) begin
      @(posedge clk_i);
    end
    pending_grads.push_back(want);
  endtask

  // Waits until every expected word is back, then lets the pipeline empty.
  task automatic drain_pipeline();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_grads.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PipeLatency + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [DataW-1:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    case (idx)
      CfgStiffness:  k_shadow    = longint'(value);
      CfgRestLength: rest_shadow = longint'(value);
      CfgDamping:    damp_shadow = longint'(value);
      default: ;
    endcase
  endtask

  // Only called while the unit is idle.
  task automatic set_spring(logic [DataW-1:0] k, logic [DataW-1:0] l0,
                            logic [DataW-1:0] b);
    write_reg(CfgStiffness, k);
    write_reg(CfgRestLength, l0);
    write_reg(CfgDamping, b);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // A Q16.16 value: mostly moderate magnitudes so the force stays in range,
  // with full-range noise and the extremes mixed in.
  function automatic logic signed [DataW-1:0] rand_q16();
    case ($urandom_range(7))
      0:       rand_q16 = $urandom();
      1:       rand_q16 = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      2:       rand_q16 = 32'($signed($urandom_range(8)) - 4);
      default: rand_q16 = 32'($signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000);
    endcase
  endfunction

  function automatic in_word_t rand_spring();
    in_word_t w;
    w.index_a = IdxW'($urandom());
    w.index_b = IdxW'($urandom());
    w.pos_ax  = rand_q16();
    w.pos_ay  = rand_q16();
    // Some springs have coincident or nearly coincident endpoints.
    if ($urandom_range(15) == 0) begin
      w.pos_bx = w.pos_ax;
      w.pos_by = w.pos_ay;
    end else begin
      w.pos_bx = rand_q16();
      w.pos_by = rand_q16();
    end
    w.vel_ax = rand_q16();
    w.vel_ay = rand_q16();
    w.vel_bx = rand_q16();
    w.vel_by = rand_q16();
    return w;
  endfunction

  function automatic in_word_t make_spring(logic [IdxW-1:0] ia, logic [IdxW-1:0] ib,
                                           int ax, int ay, int bx, int by,
                                           int vax, int vay, int vbx, int vby);
    in_word_t w;
    w.index_a = ia;
    w.index_b = ib;
    w.pos_ax  = ax;
    w.pos_ay  = ay;
    w.pos_bx  = bx;
    w.pos_by  = by;
    w.vel_ax  = vax;
    w.vel_ay  = vay;
    w.vel_bx  = vbx;
    w.vel_by  = vby;
    return w;
  endfunction

  // Hand-picked springs under reset values and then under extreme settings.
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // Spring along x at twice the rest length, then along y, then compressed.
    send_spring(make_spring(0, 1, 0, 0, 32'h0002_0000, 0, 0, 0, 0, 0));
    send_spring(make_spring(1023, 0, 0, 0, 0, -32'sh0003_0000, 0, 0, 0, 0));
    send_spring(make_spring(5, 5, 32'h0001_0000, 32'h0001_0000, 32'h0001_4000,
                            32'h0001_4000, 0, 0, 0, 0));
    // Coincident endpoints give the degenerate flag.
    send_spring(make_spring(7, 8, 32'h1234_5678, -32'sh0000_0042, 32'h1234_5678,
                            -32'sh0000_0042, 32'h0001_0000, 0, 0, 0));
    send_spring(make_spring(1023, 1023, 32'sh8000_0000, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh8000_0000, 0, 0, 0, 0));
    // Widest separation in both axes, in both directions.
    send_spring(make_spring(3, 4, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 0, 0, 0, 0));
    send_spring(make_spring(4, 3, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000,
                            32'sh8000_0000, 32'sh7FFF_FFFF));
    // Smallest nonzero separation.
    send_spring(make_spring(9, 10, 0, 0, 1, 0, 0, 0, 0, 0));
    send_spring(make_spring(9, 10, 0, 0, 0, -1, 0, 0, 0, 0));
    drain_pipeline();
    // Strong damping, with stiffness off: only the velocity term acts.
    set_spring(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
    send_spring(make_spring(11, 12, 0, 0, 32'h0001_0000, 0, 0, 0, 32'h0002_0000, 0));
    send_spring(make_spring(11, 12, 0, 0, 32'h0001_0000, 32'h0001_0000,
                            32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF));
    send_spring(make_spring(13, 14, 0, 0, 0, 32'h0000_0100, 0, 32'h0000_4000, 0, 0));
    drain_pipeline();
    // Largest stiffness and rest length: saturation in both directions.
    set_spring(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    send_spring(make_spring(15, 16, 0, 0, 32'h0001_0000, 0, 0, 0, 0, 0));
    send_spring(make_spring(15, 16, 32'sh8000_0000, 0, 32'sh7FFF_FFFF, 0, 0, 0, 0, 0));
    set_spring_after_drain(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    send_spring(make_spring(17, 18, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
                            32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
                            32'sh8000_0000, 32'sh8000_0000));
    send_spring(make_spring(19, 20, 0, 0, 32'h0000_0300, 32'h0000_0400, 5, -7, 9, 11));
    drain_pipeline();
  endtask

  task automatic set_spring_after_drain(logic [DataW-1:0] k, logic [DataW-1:0] l0,
                                        logic [DataW-1:0] b);
    drain_pipeline();
    set_spring(k, l0, b);
  endtask

  task automatic run_random(int count, int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      send_spring(rand_spring());
    end
    drain_pipeline();
  endtask

  task automatic test_random_no_idle();
    set_spring(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
    run_random(240, 0, 0);
  endtask

  task automatic test_random_sender_idle();
    set_spring(32'h0000_8000, 32'h0004_0000, 32'h0000_2000);
    run_random(240, 57, 0);
  endtask

  task automatic test_random_receiver_stall();
    set_spring($urandom(), $urandom_range(32'h0010_0000), $urandom_range(32'h0003_0000));
    run_random(240, 0, 57);
  endtask

  task automatic test_random_both_idle();
    set_spring(32'h0003_0000, 32'h0000_0000, 32'h0001_0000);
    run_random(230, 15, 15);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    if (pending_grads.size() != 0) begin
      $display("%0t %0d expected words never arrived", $time, pending_grads.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
